// ===== sv/sss_pkg.sv =====
package sss_pkg;

  // Clamp bounds for every phase length, in milliseconds
  localparam int unsigned MIN_PULSE_MS = 1;
  localparam int unsigned MAX_PULSE_MS = 250;

  // Default microsecond ticks per millisecond
  localparam int unsigned TICKS_PER_MS_DEF = 1000;

  // Remaining-shot code for full auto
  localparam logic [15:0] SHOTS_UNLIMITED = 16'hFFFF;

  // Two-valve selection value of solenoid_count
  localparam logic [1:0] TWO_VALVES = 2'd2;

  // Register values after reset
  localparam logic [1:0]  RST_SOLENOID_COUNT = 2'd1;
  localparam logic [15:0] RST_NOZZLE_MS      = 16'd10;
  localparam logic [15:0] RST_RETURN_MS      = 16'd5;
  localparam logic [15:0] RST_POPPET_MS      = 16'd15;
  localparam logic [15:0] RST_POST_MS        = 16'd20;

  localparam int CFG_DATA_W = 20;

  // Input opcodes
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_TRIGGER = 2'd1,
    OP_STOP    = 2'd2
  } opcode_t;

  // Fire modes
  typedef enum logic [1:0] {
    FM_SAFE  = 2'd0,
    FM_SEMI  = 2'd1,
    FM_FULL  = 2'd2,
    FM_BURST = 2'd3
  } fire_mode_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_SOLENOID_COUNT = 3'd0,
    CFG_NOZZLE_MS      = 3'd1,
    CFG_RETURN_MS      = 3'd2,
    CFG_POPPET_MS      = 3'd3,
    CFG_POST_MS        = 3'd4,
    CFG_MIN_INTERVAL   = 3'd5,
    CFG_SEMI_RATE      = 3'd6,
    CFG_SWAP_OUTPUTS   = 3'd7
  } cfg_idx_t;

  // One result transaction
  typedef struct packed {
    logic        drive_one;
    logic        drive_two;
    logic        busy_res;
    logic        semi_blocked;
    logic [31:0] total_shots;
    logic [15:0] shots_left;
  } result_t;

  // Clamp a length in ms, scale to ticks, saturate at 32 bits
  function automatic logic [31:0] phase_ticks(input logic [15:0] ms,
                                              input int unsigned tpm);
    logic [15:0] clamped;
    logic [47:0] prod;
    clamped = ms;
    if (ms < 16'(MIN_PULSE_MS)) begin
      clamped = 16'(MIN_PULSE_MS);
    end else if (ms > 16'(MAX_PULSE_MS)) begin
      clamped = 16'(MAX_PULSE_MS);
    end
    prod = 48'(clamped) * 48'(tpm);
    if (prod > 48'h0000_FFFF_FFFF) begin
      return 32'hFFFF_FFFF;
    end
    return prod[31:0];
  endfunction

endpackage

// ===== sv/solenoid_shot_sequencer_unit.sv =====
// A result is registered in the output slot, or in the skid entry while the output slot is held.
// Throughput: one transaction per clock; the two-entry result buffer stalls the
// input only while its skid entry holds a result, that is while both entries are full.
// Reset (rst_n low, synchronous): sequencer idle, counters cleared, interval
// timer saturated, registers back to their defaults; no clearing pass.
module solenoid_shot_sequencer_unit #(
  parameter int unsigned TICKS_PER_MS = sss_pkg::TICKS_PER_MS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic        in_trigger_pressed,
  input  logic [1:0]  in_fire_mode,
  input  logic [7:0]  in_burst_shots,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_drive_one,
  output logic        out_drive_two,
  output logic        out_busy_res,
  output logic        out_semi_blocked,
  output logic [31:0] out_total_shots,
  output logic [15:0] out_shots_left,
  // configuration port
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [sss_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Millisecond prescaler width follows the tick rate
  localparam int PSW = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;
  localparam logic [PSW:0] TPM_W = (PSW + 1)'(TICKS_PER_MS);
  localparam logic [19:0] SINCE_MAX = 20'hFFFFF;
  localparam logic [15:0] SEMI_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_NOZZLE = 3'd1,
    PH_RETURN = 3'd2,
    PH_POPPET = 3'd3,
    PH_POST   = 3'd4
  } phase_t;

  // Configuration; phase lengths are stored already clamped and in ticks
  logic [1:0]  sol_count_r;
  logic [31:0] nozzle_tk_r, return_tk_r, poppet_tk_r, post_tk_r;
  logic [19:0] min_iv_r;
  logic [15:0] semi_rate_r;
  logic        swap_r;

  // Sequencer state
  phase_t      phase_r, phase_nxt;
  logic [31:0] countdown_r, countdown_nxt;
  logic [19:0] since_shot_r, since_shot_nxt;
  logic        held_r, held_nxt;
  logic        armed_r, armed_nxt;
  logic [15:0] remaining_r, remaining_nxt;
  logic [31:0] shot_cnt_r, shot_cnt_nxt;
  logic        was_semi_r, was_semi_nxt;
  logic        semi_seen_r, semi_seen_nxt;
  logic [15:0] since_semi_r, since_semi_nxt;
  logic [PSW-1:0] prescale_r, prescale_nxt;

  logic [PSW:0] pre_inc;
  logic         accept;
  logic         two_valves;
  sss_pkg::fire_mode_t mode;
  sss_pkg::result_t    res;
  logic         nozzle_on, poppet_on;

  assign accept     = in_valid && !in_stall;
  assign two_valves = (sol_count_r == sss_pkg::TWO_VALVES);
  assign mode       = sss_pkg::fire_mode_t'(in_fire_mode);
  assign pre_inc    = {1'b0, prescale_r} + (PSW + 1)'(1);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sol_count_r <= sss_pkg::RST_SOLENOID_COUNT;
      nozzle_tk_r <= sss_pkg::phase_ticks(sss_pkg::RST_NOZZLE_MS, TICKS_PER_MS);
      return_tk_r <= sss_pkg::phase_ticks(sss_pkg::RST_RETURN_MS, TICKS_PER_MS);
      poppet_tk_r <= sss_pkg::phase_ticks(sss_pkg::RST_POPPET_MS, TICKS_PER_MS);
      post_tk_r   <= sss_pkg::phase_ticks(sss_pkg::RST_POST_MS, TICKS_PER_MS);
      min_iv_r    <= '0;
      semi_rate_r <= '0;
      swap_r      <= 1'b0;
    end else if (cfg_wr_en) begin
      case (sss_pkg::cfg_idx_t'(cfg_index))
        sss_pkg::CFG_SOLENOID_COUNT: sol_count_r <= cfg_wdata[1:0];
        sss_pkg::CFG_NOZZLE_MS:
          nozzle_tk_r <= sss_pkg::phase_ticks(cfg_wdata[15:0], TICKS_PER_MS);
        sss_pkg::CFG_RETURN_MS:
          return_tk_r <= sss_pkg::phase_ticks(cfg_wdata[15:0], TICKS_PER_MS);
        sss_pkg::CFG_POPPET_MS:
          poppet_tk_r <= sss_pkg::phase_ticks(cfg_wdata[15:0], TICKS_PER_MS);
        sss_pkg::CFG_POST_MS:
          post_tk_r <= sss_pkg::phase_ticks(cfg_wdata[15:0], TICKS_PER_MS);
        sss_pkg::CFG_MIN_INTERVAL:   min_iv_r    <= cfg_wdata[19:0];
        sss_pkg::CFG_SEMI_RATE:      semi_rate_r <= cfg_wdata[15:0];
        sss_pkg::CFG_SWAP_OUTPUTS:   swap_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Next state for one accepted transaction
  always_comb begin
    phase_nxt      = phase_r;
    countdown_nxt  = countdown_r;
    since_shot_nxt = since_shot_r;
    held_nxt       = held_r;
    armed_nxt      = armed_r;
    remaining_nxt  = remaining_r;
    shot_cnt_nxt   = shot_cnt_r;
    was_semi_nxt   = was_semi_r;
    semi_seen_nxt  = semi_seen_r;
    since_semi_nxt = since_semi_r;
    prescale_nxt   = prescale_r;
    if (accept) begin
      case (sss_pkg::opcode_t'(in_opcode))
        sss_pkg::OP_TICK: begin
          // time counters advance first, saturating
          if (since_shot_r != SINCE_MAX) since_shot_nxt = since_shot_r + 20'd1;
          if (pre_inc >= TPM_W) begin
            prescale_nxt = '0;
            if (since_semi_r != SEMI_MAX) since_semi_nxt = since_semi_r + 16'd1;
          end else begin
            prescale_nxt = pre_inc[PSW-1:0];
          end
          if (phase_r == PH_IDLE) begin
            if (mode == sss_pkg::FM_SAFE) begin
              armed_nxt     = 1'b0;
              remaining_nxt = '0;
            end else if (armed_r && remaining_r != '0) begin
              if (mode == sss_pkg::FM_FULL && !held_r) begin
                armed_nxt = 1'b0;
              end else if (min_iv_r == '0 || since_shot_nxt >= min_iv_r) begin
                // shot start
                phase_nxt      = two_valves ? PH_NOZZLE : PH_POPPET;
                countdown_nxt  = two_valves ? nozzle_tk_r : poppet_tk_r;
                since_shot_nxt = '0;
                shot_cnt_nxt   = shot_cnt_r + 32'd1;
              end
            end
          end else if (countdown_r > 32'd1) begin
            countdown_nxt = countdown_r - 32'd1;
          end else begin
            case (phase_r)
              PH_NOZZLE: begin
                phase_nxt     = PH_RETURN;
                countdown_nxt = return_tk_r;
              end
              PH_RETURN: begin
                phase_nxt     = PH_POPPET;
                countdown_nxt = poppet_tk_r;
              end
              PH_POPPET: begin
                phase_nxt     = PH_POST;
                countdown_nxt = two_valves ? post_tk_r : return_tk_r;
                if (remaining_r != sss_pkg::SHOTS_UNLIMITED && remaining_r != '0) begin
                  remaining_nxt = remaining_r - 16'd1;
                end
              end
              default: begin
                // end of cycle
                phase_nxt     = PH_IDLE;
                countdown_nxt = '0;
                if (remaining_r == '0) begin
                  armed_nxt = 1'b0;
                  if (was_semi_r) begin
                    semi_seen_nxt  = 1'b1;
                    since_semi_nxt = '0;
                  end
                end
              end
            endcase
          end
        end
        sss_pkg::OP_TRIGGER: begin
          held_nxt = in_trigger_pressed;
          if (mode == sss_pkg::FM_SAFE) begin
            armed_nxt     = 1'b0;
            remaining_nxt = '0;
          end else if (in_trigger_pressed) begin
            armed_nxt    = 1'b1;
            was_semi_nxt = (mode == sss_pkg::FM_SEMI);
            case (mode)
              sss_pkg::FM_SEMI: remaining_nxt = 16'd1;
              sss_pkg::FM_FULL: remaining_nxt = sss_pkg::SHOTS_UNLIMITED;
              default:          remaining_nxt = 16'(in_burst_shots);
            endcase
          end else if (mode == sss_pkg::FM_FULL) begin
            remaining_nxt = '0;
          end
        end
        sss_pkg::OP_STOP: begin
          phase_nxt     = PH_IDLE;
          countdown_nxt = '0;
          armed_nxt     = 1'b0;
          remaining_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  // Sequencer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      countdown_r  <= '0;
      since_shot_r <= SINCE_MAX;
      held_r       <= 1'b0;
      armed_r      <= 1'b0;
      remaining_r  <= '0;
      shot_cnt_r   <= '0;
      was_semi_r   <= 1'b0;
      semi_seen_r  <= 1'b0;
      since_semi_r <= '0;
      prescale_r   <= '0;
    end else begin
      phase_r      <= phase_nxt;
      countdown_r  <= countdown_nxt;
      since_shot_r <= since_shot_nxt;
      held_r       <= held_nxt;
      armed_r      <= armed_nxt;
      remaining_r  <= remaining_nxt;
      shot_cnt_r   <= shot_cnt_nxt;
      was_semi_r   <= was_semi_nxt;
      semi_seen_r  <= semi_seen_nxt;
      since_semi_r <= since_semi_nxt;
      prescale_r   <= prescale_nxt;
    end
  end

  // Result fields decoded from the updated state
  assign nozzle_on = (phase_nxt == PH_NOZZLE);
  assign poppet_on = (phase_nxt == PH_POPPET);

  always_comb begin
    res.drive_one    = swap_r ? nozzle_on : poppet_on;
    res.drive_two    = swap_r ? poppet_on : nozzle_on;
    res.busy_res     = (phase_nxt != PH_IDLE);
    res.semi_blocked = (semi_rate_r != '0) && semi_seen_nxt &&
                       (since_semi_nxt < semi_rate_r);
    res.total_shots  = shot_cnt_nxt;
    res.shots_left   = remaining_nxt;
  end

  sss_pkg::result_t out_res;

  sss_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_data  (res),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_res)
  );

  assign out_drive_one    = out_res.drive_one;
  assign out_drive_two    = out_res.drive_two;
  assign out_busy_res     = out_res.busy_res;
  assign out_semi_blocked = out_res.semi_blocked;
  assign out_total_shots  = out_res.total_shots;
  assign out_shots_left   = out_res.shots_left;

`ifndef SYNTHESIS
  // A shot count step is a single increment that starts a timed phase
  a_shot_start: assert property (@(posedge clk) disable iff (!rst_n)
    (shot_cnt_nxt != shot_cnt_r) |->
      (shot_cnt_nxt == shot_cnt_r + 32'd1) && (since_shot_nxt == '0) &&
      (phase_nxt != PH_IDLE))
    else $error("shot counter moved without a shot start");

  // Leaving idle needs an armed cycle with shots left
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE && phase_nxt != PH_IDLE) |->
      (armed_r && remaining_r != '0))
    else $error("sequence started while not armed");

  // After every accepted transaction the output slot holds a valid result next cycle
  a_result_next: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  // The two drives are never on together
  a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_drive_one && out_drive_two))
    else $error("both solenoid drives active");
`endif

endmodule

// ===== sv/sss_skid.sv =====
// Two-entry result buffer: output register plus one skid entry
module sss_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  sss_pkg::result_t  in_data,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output sss_pkg::result_t  out_data
);

  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  sss_pkg::result_t out_data_r, out_data_nxt;
  sss_pkg::result_t skid_data_r, skid_data_nxt;
  logic             push, pop;

  assign in_stall  = skid_valid_r;
  assign push      = in_valid && !skid_valid_r;
  assign pop       = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Refill the output slot from skid first, then from the input; an input that finds the output slot held goes to skid
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_data_nxt  = in_data;
        out_valid_nxt = push;
      end
    end else if (push) begin
      skid_data_nxt  = in_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule
